FILE: rtl/osis_pkg.sv
`default_nettype none

package osis_pkg;

  // fixed widths
  localparam int unsigned CFG_W    = 56;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DEG_W    = 16;

  // number of set-up register writes after power up
  localparam int unsigned SETUP_STEPS = 7;

  // input queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // event kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_REQ   = 2'd2;
  localparam logic [1:0] KIND_FAIL  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SETUP_REGS = 2'd0;
  localparam logic [1:0] CFG_SETUP_VALS = 2'd1;
  localparam logic [1:0] CFG_DEV_ADDR   = 2'd2;

  localparam logic [CFG_W-1:0] SETUP_REGS_RST = 56'h34335432575655;
  localparam logic [CFG_W-1:0] SETUP_VALS_RST = 56'h0107060A01010A;
  localparam logic [6:0]       DEV_ADDR_RST   = 7'h28;

  // sensor registers
  localparam logic [7:0] REG_STATUS  = 8'h37;
  localparam logic [7:0] REG_RESET   = 8'h9B;
  localparam logic [7:0] REG_EVENTS  = 8'h35;
  localparam logic [7:0] REG_HEADING = 8'h00;
  localparam logic [7:0] REG_PITCH   = 8'h04;
  localparam logic [7:0] REG_ROLL    = 8'h08;

  localparam logic [7:0] RESET_CMD   = 8'h01;

  localparam logic [2:0] NB_STATUS   = 3'd1;
  localparam logic [2:0] NB_ANGLE    = 3'd4;

  // phases
  localparam logic [1:0] PH_POWER  = 2'd0;
  localparam logic [1:0] PH_SETUP  = 2'd1;
  localparam logic [1:0] PH_NORMAL = 2'd2;
  localparam logic [1:0] PH_RESET  = 2'd3;

  localparam logic [1:0] AXIS_HEADING = 2'd0;
  localparam logic [1:0] AXIS_PITCH   = 2'd1;
  localparam logic [1:0] AXIS_ROLL    = 2'd2;

  // angle scaling: d = floor(|f| * 9000 / 157)
  localparam logic [13:0] ANG_MUL   = 14'd9000;
  localparam logic [7:0]  ANG_DIV   = 8'd157;
  localparam logic [24:0] DIV_RECIP = 25'd27356479;   // floor(2^32 / 157)
  localparam logic [23:0] SAT_LIMIT = 24'd10289152;   // 65536 * 157
  localparam logic [7:0]  EXP_BIG   = 8'd150;
  localparam logic [7:0]  EXP_INF   = 8'hFF;
  localparam logic [15:0] ANG_ZERO  = 16'd180;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] response_data;
  } in_t;

  typedef struct packed {
    logic             cmd_valid;
    logic             cmd_write;
    logic [6:0]       cmd_address;
    logic [7:0]       cmd_register;
    logic [7:0]       cmd_value;
    logic [2:0]       cmd_read_bytes;
    logic             angle_valid;
    logic [1:0]       angle_axis;
    logic [DEG_W-1:0] angle_degrees;
    logic [1:0]       phase;
  } out_t;

  // classified event handed from front to back
  typedef struct packed {
    logic              is_start;
    logic              is_done;
    logic              is_req;
    logic [DATA_W-1:0] data;
  } evt_t;

endpackage

`default_nettype wire

FILE: rtl/osis_front.sv
`default_nettype none

module osis_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire osis_pkg::in_t in_data,
  output logic               q_valid,
  output osis_pkg::evt_t     q_evt,
  input  wire logic          q_pop
);

  osis_pkg::in_t mem [osis_pkg::QDEPTH];

  logic [osis_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [osis_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [osis_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        push;
  logic                        pop;
  osis_pkg::in_t               head;

  assign in_stall = (cnt_r == osis_pkg::QCNT_W'(osis_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_data;
    end
  end

  // classify the head beat by kind; failures carry no flag
  always_comb begin
    q_evt          = '0;
    q_evt.data     = head.response_data;
    unique case (head.kind)
      osis_pkg::KIND_START: q_evt.is_start = 1'b1;
      osis_pkg::KIND_DONE:  q_evt.is_done  = 1'b1;
      osis_pkg::KIND_REQ:   q_evt.is_req   = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= osis_pkg::QCNT_W'(osis_pkg::QDEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == osis_pkg::QCNT_W'(osis_pkg::QDEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !q_pop) |=> in_stall)
    else $error("queue lost a beat while full");
`endif

endmodule

`default_nettype wire

FILE: rtl/osis_angle.sv
`default_nettype none

module osis_angle (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [osis_pkg::DATA_W-1:0]   bits_i,
  output logic      [osis_pkg::DEG_W-1:0]    deg_o
);

  // stage A: unpack and scale mantissa by 9000
  logic [7:0]  ex;
  logic [22:0] man;
  logic        neg;
  logic        big;
  logic [23:0] m;
  logic [7:0]  e;

  logic [37:0] num_a_r;
  logic [7:0]  s_a_r;
  logic        big_a_r;
  logic        neg_a_r;

  assign ex  = bits_i[30:23];
  assign man = bits_i[22:0];
  // NaN takes the positive branch
  assign neg = bits_i[31] && !((ex == osis_pkg::EXP_INF) && (man != '0));
  assign big = (ex >= osis_pkg::EXP_BIG);
  assign m   = (ex == '0) ? {1'b0, man} : {1'b1, man};
  assign e   = (ex == '0) ? 8'd1 : ex;

  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r <= 38'(m) * 38'(osis_pkg::ANG_MUL);
      s_a_r   <= osis_pkg::EXP_BIG - e;
      big_a_r <= big;
      neg_a_r <= neg;
    end
  end

  // stage B: align, detect saturation, estimate quotient by reciprocal
  logic [37:0] x_full;
  logic        sat_b;
  logic [48:0] prod;

  logic [23:0] x_b_r;
  logic [15:0] q0_b_r;
  logic        sat_b_r;
  logic        neg_b_r;

  assign x_full = num_a_r >> s_a_r;
  assign sat_b  = big_a_r || (x_full >= 38'(osis_pkg::SAT_LIMIT));
  assign prod   = 49'(x_full[23:0]) * 49'(osis_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      x_b_r   <= x_full[23:0];
      q0_b_r  <= prod[47:32];
      sat_b_r <= sat_b;
      neg_b_r <= neg_b_r & 1'b0 | neg_a_r;
    end
  end

  // stage C: one correction step, then offset around 180
  logic [23:0] rem;
  logic [15:0] d;

  assign rem = x_b_r - 24'(q0_b_r) * 24'(osis_pkg::ANG_DIV);

  always_comb begin
    if (sat_b_r) begin
      d = '1;
    end else if (rem >= 24'(osis_pkg::ANG_DIV)) begin
      d = q0_b_r + 16'd1;
    end else begin
      d = q0_b_r;
    end
    deg_o = neg_b_r ? (osis_pkg::ANG_ZERO - d) : (osis_pkg::ANG_ZERO + d);
  end

endmodule

`default_nettype wire

FILE: rtl/orientation_sensor_i2c_sequencer_top.sv
// Each accepted input beat is registered in turn by the queue write, then the sequencer with
// angle stage A, angle stage B and the output register before its result beat is valid.
// Throughput: one beat per cycle; the back pipeline advances whenever the output
// register is empty or taken, and a 4-entry queue decouples the input side.
// Reset (rst_n low, synchronous): queue empty, pipeline empty, phase power up,
// set-up step 0, last register 0, configuration registers to their defaults.
`default_nettype none

module orientation_sensor_i2c_sequencer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire osis_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output osis_pkg::out_t                   out_data,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [osis_pkg::CFG_W-1:0]  cfg_wdata
);

  // configuration
  logic [osis_pkg::CFG_W-1:0] setup_regs_r;
  logic [osis_pkg::CFG_W-1:0] setup_vals_r;
  logic [6:0]                 dev_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_regs_r <= osis_pkg::SETUP_REGS_RST;
      setup_vals_r <= osis_pkg::SETUP_VALS_RST;
      dev_addr_r   <= osis_pkg::DEV_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        osis_pkg::CFG_SETUP_REGS: setup_regs_r <= cfg_wdata;
        osis_pkg::CFG_SETUP_VALS: setup_vals_r <= cfg_wdata;
        osis_pkg::CFG_DEV_ADDR:   dev_addr_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // front: queue and classification
  logic           q_valid;
  osis_pkg::evt_t ev;
  logic           adv;
  logic           pop;

  osis_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_evt    (ev),
    .q_pop    (pop)
  );

  logic           out_valid_r;
  osis_pkg::out_t out_r;

  assign adv = !(out_valid_r && out_stall);
  assign pop = q_valid && adv;

  // sequencer state
  logic [1:0] ph_r, ph_nxt;
  logic [2:0] step_r, step_nxt;
  logic [7:0] last_r, last_nxt;

  logic [63:0] sr_ext;
  logic [63:0] sv_ext;
  logic [7:0]  su_reg;
  logic [7:0]  su_val;
  logic        su_has;
  logic [7:0]  b0;

  logic        iss;
  logic        iss_wr;
  logic [7:0]  iss_reg;
  logic [7:0]  iss_val;
  logic [2:0]  iss_nb;
  logic        ang_v;
  logic [1:0]  ang_axis;

  osis_pkg::out_t res1;

  assign sr_ext = {8'h00, setup_regs_r};
  assign sv_ext = {8'h00, setup_vals_r};
  assign su_reg = sr_ext[{step_r, 3'b000} +: 8];
  assign su_val = sv_ext[{step_r, 3'b000} +: 8];
  assign su_has = (step_r < 3'(osis_pkg::SETUP_STEPS));
  assign b0     = ev.data[7:0];

  always_comb begin
    ph_nxt   = ph_r;
    step_nxt = step_r;
    last_nxt = last_r;
    iss      = 1'b0;
    iss_wr   = 1'b0;
    iss_reg  = '0;
    iss_val  = '0;
    iss_nb   = '0;
    ang_v    = 1'b0;
    ang_axis = '0;

    unique case (ph_r)
      osis_pkg::PH_POWER: begin
        if (ev.is_start) begin
          iss     = 1'b1;
          iss_reg = osis_pkg::REG_STATUS;
          iss_nb  = osis_pkg::NB_STATUS;
        end else if (ev.is_done && b0[0] && b0[1]) begin
          if (b0[2]) begin
            ph_nxt  = osis_pkg::PH_RESET;
            iss     = 1'b1;
            iss_wr  = 1'b1;
            iss_reg = osis_pkg::REG_RESET;
            iss_val = osis_pkg::RESET_CMD;
          end else begin
            ph_nxt = osis_pkg::PH_SETUP;
            if (su_has) begin
              iss      = 1'b1;
              iss_wr   = 1'b1;
              iss_reg  = su_reg;
              iss_val  = su_val;
              step_nxt = step_r + 3'd1;
            end
          end
        end
      end
      osis_pkg::PH_SETUP: begin
        if (ev.is_done) begin
          if (su_has) begin
            iss      = 1'b1;
            iss_wr   = 1'b1;
            iss_reg  = su_reg;
            iss_val  = su_val;
            step_nxt = step_r + 3'd1;
          end else begin
            ph_nxt  = osis_pkg::PH_NORMAL;
            iss     = 1'b1;
            iss_reg = osis_pkg::REG_EVENTS;
            iss_nb  = osis_pkg::NB_STATUS;
          end
        end
      end
      osis_pkg::PH_NORMAL: begin
        if (ev.is_req) begin
          iss     = 1'b1;
          iss_reg = osis_pkg::REG_EVENTS;
          iss_nb  = osis_pkg::NB_STATUS;
        end else if (ev.is_done) begin
          if (last_r == osis_pkg::REG_EVENTS) begin
            // error bit wins over new-result bit
            if (b0[1]) begin
              ph_nxt  = osis_pkg::PH_RESET;
              iss     = 1'b1;
              iss_wr  = 1'b1;
              iss_reg = osis_pkg::REG_RESET;
              iss_val = osis_pkg::RESET_CMD;
            end else if (b0[2]) begin
              iss     = 1'b1;
              iss_reg = osis_pkg::REG_HEADING;
              iss_nb  = osis_pkg::NB_ANGLE;
            end
          end else if (last_r == osis_pkg::REG_HEADING) begin
            ang_v    = 1'b1;
            ang_axis = osis_pkg::AXIS_HEADING;
            iss      = 1'b1;
            iss_reg  = osis_pkg::REG_PITCH;
            iss_nb   = osis_pkg::NB_ANGLE;
          end else if (last_r == osis_pkg::REG_PITCH) begin
            ang_v    = 1'b1;
            ang_axis = osis_pkg::AXIS_PITCH;
            iss      = 1'b1;
            iss_reg  = osis_pkg::REG_ROLL;
            iss_nb   = osis_pkg::NB_ANGLE;
          end else if (last_r == osis_pkg::REG_ROLL) begin
            ang_v    = 1'b1;
            ang_axis = osis_pkg::AXIS_ROLL;
          end
        end
      end
      default: begin
        if (ev.is_done) begin
          ph_nxt   = osis_pkg::PH_POWER;
          step_nxt = '0;
          iss      = 1'b1;
          iss_reg  = osis_pkg::REG_STATUS;
          iss_nb   = osis_pkg::NB_STATUS;
        end
      end
    endcase

    if (iss) begin
      last_nxt = iss_reg;
    end

    res1                = '0;
    res1.cmd_valid      = iss;
    res1.cmd_write      = iss_wr;
    res1.cmd_address    = iss ? dev_addr_r : 7'd0;
    res1.cmd_register   = iss_reg;
    res1.cmd_value      = iss_val;
    res1.cmd_read_bytes = iss_nb;
    res1.angle_valid    = ang_v;
    res1.angle_axis     = ang_axis;
    res1.phase          = ph_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= osis_pkg::PH_POWER;
      step_r <= '0;
      last_r <= '0;
    end else if (pop) begin
      ph_r   <= ph_nxt;
      step_r <= step_nxt;
      last_r <= last_nxt;
    end
  end

  // back pipeline: sequencer result travels alongside the angle decoder
  logic [osis_pkg::DEG_W-1:0] deg;

  osis_angle u_angle (
    .clk    (clk),
    .en     (adv),
    .bits_i (ev.data),
    .deg_o  (deg)
  );

  logic           v1_r;
  logic           v2_r;
  osis_pkg::out_t s1_r;
  osis_pkg::out_t s2_r;
  osis_pkg::out_t out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_comb begin
    out_nxt               = s2_r;
    out_nxt.angle_degrees = s2_r.angle_valid ? deg : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= res1;
      s2_r  <= s1_r;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv) |=> out_valid_r)
    else $error("result beat lost between pipeline and output");

  a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.cmd_valid && !out_r.cmd_write) |->
      (out_r.cmd_value == '0 &&
       (out_r.cmd_read_bytes == osis_pkg::NB_STATUS ||
        out_r.cmd_read_bytes == osis_pkg::NB_ANGLE)))
    else $error("malformed read command");

  a_reset_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && ph_r == osis_pkg::PH_RESET && ev.is_done) |=>
      (ph_r == osis_pkg::PH_POWER && step_r == '0))
    else $error("reset phase did not return to power up");

  a_angle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.angle_valid) |->
      (out_r.phase == osis_pkg::PH_NORMAL && out_r.angle_axis != 2'd3))
    else $error("angle outside normal phase");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && ph_r == osis_pkg::PH_SETUP && ev.is_done && su_has) |=>
      (step_r == $past(step_r) + 3'd1))
    else $error("set-up step did not advance");
`endif

endmodule

`default_nettype wire
